>>> rtl/bav_pkg.sv
// shared types, constants and register codes for the button auto-repeat value adjuster
// no dependencies; used by bav_step and button_autorepeat_value_adjust
package bav_pkg;

	localparam int VALUE_BITS = 16;
	localparam int TIMER_BITS = 16;
	localparam int CMP_BITS   = 33;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_DELAY    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_PERIOD = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ESC_HOLD_TIME = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_VALUE_MAX     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MS_WRAP       = 3'd4;

	localparam logic [15:0] RST_HOLD_DELAY    = 16'd500;
	localparam logic [15:0] RST_REPEAT_PERIOD = 16'd200;
	localparam logic [15:0] RST_ESC_HOLD_TIME = 16'd2000;
	localparam logic [15:0] RST_VALUE_MAX     = 16'd65535;
	localparam logic [31:0] RST_MS_WRAP       = 32'd4233600000;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_POLL = 2'd1;
	localparam logic [1:0] REQ_LOAD = 2'd2;

	localparam logic [1:0] FLAG_NONE  = 2'd0;
	localparam logic [1:0] FLAG_FRESH = 2'd1;
	localparam logic [1:0] FLAG_DONE  = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        up_pressed;
		logic        down_pressed;
		logic        esc_pressed;
		logic [1:0]  up_flag;
		logic [1:0]  down_flag;
		logic        clear_escape;
		logic [15:0] new_value;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] value_out;
		logic        escape_out;
		logic [1:0]  up_flag_out;
		logic [1:0]  down_flag_out;
		logic [31:0] ms_time;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] hold_delay;
		logic [15:0] repeat_period;
		logic [15:0] esc_hold_time;
		logic [15:0] value_max;
		logic [31:0] ms_wrap;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] adj_value;
		logic                  escape_state;
		logic                  up_active;
		logic                  down_active;
		logic                  esc_active;
		logic [TIMER_BITS-1:0] hold_count;
		logic [TIMER_BITS-1:0] repeat_timer;
		logic [TIMER_BITS-1:0] esc_timer;
		logic [31:0]           ms_count;
	} state_t;

endpackage

>>> rtl/bav_step.sv
// next-state and result logic for one beat: poll, tick and load handling
// depends on bav_pkg
module bav_step (
	input  bav_pkg::state_t    st,
	input  bav_pkg::cfg_t      cfg,
	input  bav_pkg::in_beat_t  beat,
	output bav_pkg::state_t    st_nxt,
	output bav_pkg::out_beat_t res
);

	logic [bav_pkg::VALUE_BITS-1:0] v1, v2, v3, v4;
	logic [bav_pkg::TIMER_BITS-1:0] rt1, hc_t, rt_t;
	logic [1:0]                     uf, df;
	logic                           esc0, up_rep, dn_rep, esc_arm, esc_fire;
	logic [bav_pkg::CMP_BITS-1:0]   ms_inc;

	function automatic logic [bav_pkg::VALUE_BITS-1:0] step_up(
		input logic [bav_pkg::VALUE_BITS-1:0] v,
		input logic [15:0]                    vmax
	);
		logic ok;
		ok = (bav_pkg::CMP_BITS'(v) < bav_pkg::CMP_BITS'(vmax)) && (v != '1);
		return ok ? v + 1'b1 : v;
	endfunction

	function automatic logic [bav_pkg::VALUE_BITS-1:0] step_dn(
		input logic [bav_pkg::VALUE_BITS-1:0] v
	);
		return (v != '0) ? v - 1'b1 : v;
	endfunction

	function automatic logic [bav_pkg::TIMER_BITS-1:0] tinc(
		input logic [bav_pkg::TIMER_BITS-1:0] t
	);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	// poll path
	always_comb begin
		esc0 = beat.clear_escape ? 1'b0 : st.escape_state;
		uf   = (beat.up_flag == bav_pkg::FLAG_FRESH) ? bav_pkg::FLAG_DONE : beat.up_flag;
		df   = (beat.down_flag == bav_pkg::FLAG_FRESH) ? bav_pkg::FLAG_DONE : beat.down_flag;
		v1   = (beat.up_flag == bav_pkg::FLAG_FRESH) ? step_up(st.adj_value, cfg.value_max)
			: st.adj_value;
		v2   = (beat.down_flag == bav_pkg::FLAG_FRESH) ? step_dn(v1) : v1;
		up_rep = beat.up_pressed && (bav_pkg::CMP_BITS'(st.repeat_timer)
			> bav_pkg::CMP_BITS'(cfg.repeat_period));
		v3   = up_rep ? step_up(v2, cfg.value_max) : v2;
		rt1  = up_rep ? '0 : st.repeat_timer;
		dn_rep = beat.down_pressed && (v3 != '0) && (bav_pkg::CMP_BITS'(rt1)
			> bav_pkg::CMP_BITS'(cfg.repeat_period));
		v4   = dn_rep ? v3 - 1'b1 : v3;
		esc_arm  = beat.esc_pressed && !esc0 && (uf == bav_pkg::FLAG_NONE)
			&& (df == bav_pkg::FLAG_NONE);
		esc_fire = esc_arm && (bav_pkg::CMP_BITS'(st.esc_timer)
			> bav_pkg::CMP_BITS'(cfg.esc_hold_time));
	end

	// tick path
	always_comb begin
		ms_inc = bav_pkg::CMP_BITS'(st.ms_count) + 1'b1;
		if (ms_inc >= bav_pkg::CMP_BITS'(cfg.ms_wrap)) begin
			ms_inc = '0;
		end
		if (st.up_active || st.down_active) begin
			hc_t = tinc(st.hold_count);
			rt_t = st.repeat_timer;
		end else begin
			hc_t = '0;
			rt_t = '0;
		end
		if (bav_pkg::CMP_BITS'(hc_t) > bav_pkg::CMP_BITS'(cfg.hold_delay)) begin
			rt_t = tinc(rt_t);
		end
	end

	always_comb begin
		st_nxt = st;
		res.up_flag_out   = beat.up_flag;
		res.down_flag_out = beat.down_flag;
		case (beat.req_type)
			bav_pkg::REQ_TICK: begin
				st_nxt.ms_count     = ms_inc[31:0];
				st_nxt.hold_count   = hc_t;
				st_nxt.repeat_timer = rt_t;
				if (st.esc_active) begin
					st_nxt.esc_timer = tinc(st.esc_timer);
				end
			end
			bav_pkg::REQ_POLL: begin
				res.up_flag_out     = uf;
				res.down_flag_out   = df;
				st_nxt.adj_value    = v4;
				st_nxt.up_active    = beat.up_pressed;
				st_nxt.down_active  = beat.down_pressed;
				st_nxt.repeat_timer = dn_rep ? '0 : rt1;
				st_nxt.escape_state = esc0 || esc_fire;
				st_nxt.esc_active   = esc_arm ? !esc_fire : st.esc_active;
				st_nxt.esc_timer    = esc_fire ? '0 : st.esc_timer;
				if (!beat.esc_pressed) begin
					st_nxt.esc_timer  = '0;
					st_nxt.esc_active = 1'b0;
				end
			end
			bav_pkg::REQ_LOAD: begin
				st_nxt.adj_value = bav_pkg::VALUE_BITS'(bav_pkg::CMP_BITS'(beat.new_value));
			end
			default: begin
				st_nxt = st;
			end
		endcase
		res.value_out  = 16'(bav_pkg::CMP_BITS'(st_nxt.adj_value));
		res.escape_out = st_nxt.escape_state;
		res.ms_time    = st_nxt.ms_count;
	end

endmodule

>>> rtl/button_autorepeat_value_adjust.sv
// top level of the button auto-repeat value adjuster: config registers, state, output register
// depends on bav_pkg and bav_step
//
// usage:
// in channel (in_valid/in_ready/in_data) carries one beat per request: a tick that
// advances the millisecond counter and the hold, repeat and escape timers, a poll that
// applies click flags, auto repeat and the escape long press, or a load of the value.
// every accepted beat yields exactly one out beat (out_valid/out_ready/out_data) with
// the value, escape latch, handled click flags and millisecond time after that beat.
// the result sits in the output register on the cycle after acceptance. throughput is
// one beat per cycle while the receiver keeps up; state updates in the cycle of
// acceptance, so the next beat may follow immediately.
// when the receiver stalls, the output register holds its beat and in_ready drops
// until the beat is taken; in_ready is high whenever the register is empty or draining.
// configuration registers are written through cfg_we/cfg_index/cfg_wdata at any edge
// with cfg_we high; writes to unknown indexes are ignored.
// reset (arst_n low) clears all state and the output register and loads the
// default timings: hold 500, repeat 200, escape 2000, max 65535, wrap 4233600000.
module button_autorepeat_value_adjust (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bav_pkg::in_beat_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bav_pkg::out_beat_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [bav_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [bav_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

	bav_pkg::cfg_t      cfg_q;
	bav_pkg::state_t    st_q, st_nxt;
	bav_pkg::out_beat_t res, out_q;
	logic               out_valid_q, acc;

	assign in_ready  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bav_step u_step (
		.st     (st_q),
		.cfg    (cfg_q),
		.beat   (in_data),
		.st_nxt (st_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_delay    <= bav_pkg::RST_HOLD_DELAY;
			cfg_q.repeat_period <= bav_pkg::RST_REPEAT_PERIOD;
			cfg_q.esc_hold_time <= bav_pkg::RST_ESC_HOLD_TIME;
			cfg_q.value_max     <= bav_pkg::RST_VALUE_MAX;
			cfg_q.ms_wrap       <= bav_pkg::RST_MS_WRAP;
		end else if (cfg_we) begin
			case (cfg_index)
				bav_pkg::REG_HOLD_DELAY:    cfg_q.hold_delay    <= cfg_wdata[15:0];
				bav_pkg::REG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_wdata[15:0];
				bav_pkg::REG_ESC_HOLD_TIME: cfg_q.esc_hold_time <= cfg_wdata[15:0];
				bav_pkg::REG_VALUE_MAX:     cfg_q.value_max     <= cfg_wdata[15:0];
				bav_pkg::REG_MS_WRAP:       cfg_q.ms_wrap       <= cfg_wdata[31:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (acc) begin
			st_q        <= st_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (acc) begin
			out_q <= res;
		end
	end

	// a fresh up click always leaves as handled
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.req_type == bav_pkg::REQ_POLL
			&& in_data.up_flag == bav_pkg::FLAG_FRESH)
		|=> (out_valid && out_data.up_flag_out == bav_pkg::FLAG_DONE))
		else $error("fresh up click not reported as handled");

	// escape latch only sets on a poll beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.escape_state) |-> $past(acc && in_data.req_type == bav_pkg::REQ_POLL))
		else $error("escape latch set outside a poll");

	// millisecond counter only moves on a tick beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.ms_count != $past(st_q.ms_count))
		|-> $past(acc && in_data.req_type == bav_pkg::REQ_TICK))
		else $error("ms counter changed without a tick");

	// every accepted beat shows up in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (out_valid && out_data.ms_time == st_q.ms_count))
		else $error("accepted beat missing from output");

endmodule
